// File: hdl/ohash_pkg.sv
// Package for the open-addressing hash table core.
// Shared constants, status and opcode codes; no dependencies.
`default_nettype none

package ohash_pkg;

  localparam int unsigned TableSlotsDefault = 1021;

  localparam int unsigned KeyWidth    = 31;
  localparam int unsigned FieldWidth  = 10;
  localparam int unsigned WordWidth   = KeyWidth + 1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_QUAD   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_REDUCE = 7'b0001000,
    S_READ   = 7'b0010000,
    S_CHECK  = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

// File: hdl/open_addressing_hash_table_core.sv
// Open-addressing hash table core: insert or search of 31-bit keys.
// Uses ohash_pkg and one ohash_ram instance for the slot store.
//
// After reset the core sweeps the slot store to empty, one slot per cycle,
// and takes no item until the sweep is done; configuration writes are taken
// meanwhile. An item then goes through S_HASH, which forms the quotients of
// the key by m and m-1 with reciprocal multiplies, S_REDUCE, which turns them
// into the home slot and the probe step (the double-hashing step in double
// mode), S_READ and S_CHECK once per probe (RAM read and the slot check), and
// S_RESP, which loads the result register. A new item is taken only once the
// core is back in S_IDLE, after the result register is loaded. The result
// register lets the next item be taken while a result waits. probe_mode
// selects linear, quadratic or double-hashing probes and may be written only
// while the core is idle.
`default_nettype none

module open_addressing_hash_table_core #(
  parameter int unsigned TABLE_SLOTS = ohash_pkg::TableSlotsDefault
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [1:0]                          cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                opcode_i,
  input  wire logic [ohash_pkg::KeyWidth-1:0]      key_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               status_o,
  output logic [ohash_pkg::FieldWidth-1:0]         slot_o,
  output logic [ohash_pkg::FieldWidth-1:0]         probe_count_o,
  output logic [ohash_pkg::FieldWidth-1:0]         occupied_count_o
);

  import ohash_pkg::*;

  localparam int unsigned IdxW  = $clog2(TABLE_SLOTS);
  localparam int unsigned CntW  = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned RecW  = KeyWidth + 2;
  localparam int unsigned ProdW = KeyWidth + RecW;
  localparam int unsigned ShM   = KeyWidth + $clog2(TABLE_SLOTS);
  localparam int unsigned ShM1  = KeyWidth + $clog2(TABLE_SLOTS - 1);
  localparam longint unsigned OneL = 1;

  // ceil(2^sh / d) gives the exact quotient for every key below 2^31
  localparam logic [RecW-1:0] RecM  =
    RecW'(((OneL << ShM) + TABLE_SLOTS - 1) / TABLE_SLOTS);
  localparam logic [RecW-1:0] RecM1 =
    RecW'(((OneL << ShM1) + TABLE_SLOTS - 2) / (TABLE_SLOTS - 1));
  localparam logic [KeyWidth-1:0] DivM  = KeyWidth'(TABLE_SLOTS);
  localparam logic [KeyWidth-1:0] DivM1 = KeyWidth'(TABLE_SLOTS - 1);

  localparam logic [IdxW-1:0] QuadD0 = IdxW'(4 % TABLE_SLOTS);
  localparam logic [IdxW-1:0] QuadDd = IdxW'(6 % TABLE_SLOTS);
  localparam logic [IdxW-1:0] LastIx = IdxW'(TABLE_SLOTS - 1);
  localparam logic [CntW-1:0] SlotsC = CntW'(TABLE_SLOTS);

  function automatic logic [IdxW-1:0] add_mod(input logic [IdxW-1:0] a,
                                              input logic [IdxW-1:0] b);
    logic [IdxW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (IdxW+1)'(TABLE_SLOTS)) begin
      sum = sum - (IdxW+1)'(TABLE_SLOTS);
    end
    return sum[IdxW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [1:0]          mode_q, mode_d;
  logic [CntW-1:0]     used_q, used_d;
  logic                out_valid_q, out_valid_d;
  logic [IdxW-1:0]     clr_q, clr_d;

  logic                op_q, op_d;
  logic [KeyWidth-1:0] key_q, key_d;
  logic [KeyWidth-1:0] quo_q, quo_d;
  logic [KeyWidth-1:0] quo1_q, quo1_d;
  logic [IdxW-1:0]     slot_q, slot_d;
  logic [IdxW-1:0]     inc_q, inc_d;
  logic [CntW-1:0]     probe_q, probe_d;
  status_e             res_st_q, res_st_d;
  logic [IdxW-1:0]     res_slot_q, res_slot_d;

  logic [1:0]          out_st_q, out_st_d;
  logic [FieldWidth-1:0] out_slot_q, out_slot_d;
  logic [FieldWidth-1:0] out_probe_q, out_probe_d;
  logic [FieldWidth-1:0] out_occ_q, out_occ_d;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  logic [WordWidth-1:0] ram_wdata;
  logic                ram_re;
  logic [WordWidth-1:0] ram_rdata;

  logic [ProdW-1:0]      prod_m;
  logic [ProdW-1:0]      prod_m1;
  logic [KeyWidth-1:0]   rem_m;
  logic [KeyWidth-1:0]   rem_m1;
  logic [CntW-1:0]       probe_nx;
  logic                  slot_full;
  logic                  slot_match;

  ohash_ram #(
    .WIDTH(WordWidth),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  assign prod_m     = ProdW'(key_q) * ProdW'(RecM);
  assign prod_m1    = ProdW'(key_q) * ProdW'(RecM1);
  assign rem_m      = key_q - quo_q * DivM;
  assign rem_m1     = key_q - quo1_q * DivM1;
  assign probe_nx   = probe_q + CntW'(1);
  assign slot_full  = ram_rdata[WordWidth-1];
  assign slot_match = (ram_rdata[KeyWidth-1:0] == key_q);
  assign ram_re     = (state_q == S_READ);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    clr_d       = clr_q;
    op_d        = op_q;
    key_d       = key_q;
    quo_d       = quo_q;
    quo1_d      = quo1_q;
    slot_d      = slot_q;
    inc_d       = inc_q;
    probe_d     = probe_q;
    res_st_d    = res_st_q;
    res_slot_d  = res_slot_q;
    out_st_d    = out_st_q;
    out_slot_d  = out_slot_q;
    out_probe_d = out_probe_q;
    out_occ_d   = out_occ_q;
    ram_we      = 1'b0;
    ram_waddr   = clr_q;
    ram_wdata   = '0;
    in_stall_o  = (state_q != S_IDLE);

    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + IdxW'(1);
        if (clr_q == LastIx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = opcode_i;
          key_d   = key_i;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        quo_d   = KeyWidth'(prod_m >> ShM);
        quo1_d  = KeyWidth'(prod_m1 >> ShM1);
        state_d = S_REDUCE;
      end
      S_REDUCE: begin
        slot_d  = rem_m[IdxW-1:0];
        probe_d = '0;
        case (mode_q)
          MODE_LINEAR: inc_d = IdxW'(1);
          MODE_QUAD:   inc_d = QuadD0;
          default:     inc_d = rem_m1[IdxW-1:0] + IdxW'(1);
        endcase
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!slot_full) begin
          if (op_q == OP_SEARCH) begin
            res_st_d   = ST_NOT_FOUND;
            res_slot_d = '0;
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = slot_q;
            ram_wdata  = {1'b1, key_q};
            used_d     = used_q + CntW'(1);
            res_st_d   = ST_INSERTED;
            res_slot_d = slot_q;
          end
          state_d = S_RESP;
        end else if (op_q == OP_SEARCH && slot_match) begin
          res_st_d   = ST_FOUND;
          res_slot_d = slot_q;
          state_d    = S_RESP;
        end else begin
          probe_d = probe_nx;
          if (probe_nx == SlotsC) begin
            res_st_d   = (op_q == OP_SEARCH) ? ST_NOT_FOUND : ST_OVERFLOW;
            res_slot_d = '0;
            state_d    = S_RESP;
          end else begin
            slot_d = add_mod(slot_q, inc_q);
            if (mode_q == MODE_QUAD) begin
              inc_d = add_mod(inc_q, QuadDd);
            end
            state_d = S_READ;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_slot_d  = FieldWidth'(res_slot_q);
          out_probe_d = FieldWidth'(probe_q);
          out_occ_d   = FieldWidth'(used_q);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      mode_q      <= MODE_DOUBLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    quo_q       <= quo_d;
    quo1_q      <= quo1_d;
    slot_q      <= slot_d;
    inc_q       <= inc_d;
    probe_q     <= probe_d;
    res_st_q    <= res_st_d;
    res_slot_q  <= res_slot_d;
    out_st_q    <= out_st_d;
    out_slot_q  <= out_slot_d;
    out_probe_q <= out_probe_d;
    out_occ_q   <= out_occ_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_st_q;
  assign slot_o           = out_slot_q;
  assign probe_count_o    = out_probe_q;
  assign occupied_count_o = out_occ_q;

endmodule

`default_nettype wire

// File: hdl/ohash_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module ohash_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: bench/open_addressing_hash_table_checker.sv
// Result checker for the open-addressing hash table core testbench.
// Watches the config, input and result channels, keeps its own copy of the slot
// store and probe mode, and compares every result; needs ohash_pkg.
module open_addressing_hash_table_checker #(
  parameter int unsigned TABLE_SLOTS = ohash_pkg::TableSlotsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             opcode_i,
  input  logic [ohash_pkg::KeyWidth-1:0]   key_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [1:0]                       status_i,
  input  logic [ohash_pkg::FieldWidth-1:0] slot_i,
  input  logic [ohash_pkg::FieldWidth-1:0] probe_count_i,
  input  logic [ohash_pkg::FieldWidth-1:0] occupied_count_i,
  output int unsigned                      error_count_o,
  output int unsigned                      pending_o,
  output int unsigned                      used_slots_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ohash_pkg::*;

  localparam longint unsigned QuadLinear = 1;
  localparam longint unsigned QuadSquare = 3;

  typedef struct packed {
    status_e               status;
    logic [FieldWidth-1:0] slot;
    logic [FieldWidth-1:0] probes;
    logic [FieldWidth-1:0] occupied;
  } lookup_result_t;

  bit                 slot_valid [TABLE_SLOTS];
  bit [KeyWidth-1:0]  slot_key   [TABLE_SLOTS];
  int unsigned        used_slots = 0;
  logic [1:0]         probe_mode = MODE_DOUBLE;
  int unsigned        mismatches = 0;
  lookup_result_t     pending_results [$];

  function automatic int unsigned probe_position(input logic [KeyWidth-1:0] k,
                                                 input int unsigned i);
    longint unsigned m, home, ii, step, pos;
    m    = TABLE_SLOTS;
    home = longint'(k) % m;
    ii   = i;
    case (probe_mode)
      MODE_LINEAR: pos = home + ii;
      MODE_QUAD:   pos = home + QuadLinear * ii + QuadSquare * ii * ii;
      default: begin
        step = 1 + longint'(k) % (m - 1);
        pos  = home + ii * step;
      end
    endcase
    return int'(pos % m);
  endfunction

  // Walks the probe sequence, updates the store on insert, returns the result.
  function automatic lookup_result_t lookup_or_place(input logic op,
                                                     input logic [KeyWidth-1:0] k);
    lookup_result_t r;
    int unsigned    i, pos;
    r.status = (op == OP_SEARCH) ? ST_NOT_FOUND : ST_OVERFLOW;
    r.slot   = '0;
    for (i = 0; i < TABLE_SLOTS; i++) begin
      pos = probe_position(k, i);
      if (!slot_valid[pos]) begin
        if (op == OP_INSERT) begin
          slot_valid[pos] = 1'b1;
          slot_key[pos]   = k;
          used_slots++;
          r.status = ST_INSERTED;
          r.slot   = pos[FieldWidth-1:0];
        end
        break;
      end
      if (op == OP_SEARCH && slot_key[pos] == k) begin
        r.status = ST_FOUND;
        r.slot   = pos[FieldWidth-1:0];
        break;
      end
    end
    r.probes   = i[FieldWidth-1:0];
    r.occupied = used_slots[FieldWidth-1:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [FieldWidth-1:0] want,
                             input logic [FieldWidth-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t want;
    if (!rst_ni) begin
      foreach (slot_valid[n]) slot_valid[n] = 1'b0;
      used_slots = 0;
      probe_mode = MODE_DOUBLE;
      pending_results.delete();
    end else begin
      if (cfg_we_i) probe_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        pending_results.push_back(lookup_or_place(opcode_i, key_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d slot %0d", $time, status_i, slot_i);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("slot", want.slot, slot_i);
          check_field("probe_count", want.probes, probe_count_i);
          check_field("occupied_count", want.occupied, occupied_count_i);
        end
      end
    end
    error_count_o <= mismatches;
    pending_o     <= pending_results.size();
    used_slots_o  <= used_slots;
  end

endmodule

// File: bench/open_addressing_hash_table_core_tb.sv
// Testbench top for open_addressing_hash_table_core: clock, reset, stimulus, verdict.
// Drives insert/search items in all probe modes up to a full table; results are
// checked by open_addressing_hash_table_checker. Needs ohash_pkg and the core.
module open_addressing_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ohash_pkg::*;

  localparam int unsigned     Slots          = TableSlotsDefault;
  localparam logic [1:0]      MODE_UNUSED    = 2'd3;
  localparam longint unsigned KeyMax         = 64'h7FFF_FFFF;
  localparam int unsigned     HotBase        = 500;
  localparam int unsigned     HotSpan        = 64;
  localparam int unsigned     PhaseItems     = 40;
  localparam int unsigned     LongHoldCycles = 300;
  localparam int unsigned     TrailCycles    = 40;
  localparam longint unsigned CycleLimit     = 12_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [1:0]            cfg_wdata = MODE_DOUBLE;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic                  opcode    = OP_INSERT;
  logic [KeyWidth-1:0]   key       = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [FieldWidth-1:0] slot;
  logic [FieldWidth-1:0] probe_count;
  logic [FieldWidth-1:0] occupied_count;

  int unsigned         error_count;
  int unsigned         pending;
  int unsigned         used_slots;
  bit                  no_idle   = 1'b0;
  bit                  long_hold = 1'b0;
  int unsigned         inserts   = 0;
  int unsigned         searches  = 0;
  longint unsigned     cycles    = 0;
  logic [KeyWidth-1:0] key_pool [$];

  open_addressing_hash_table_core #(.TABLE_SLOTS(Slots)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .key_i            (key),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .slot_o           (slot),
    .probe_count_o    (probe_count),
    .occupied_count_o (occupied_count)
  );

  open_addressing_hash_table_checker #(.TABLE_SLOTS(Slots)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .key_i            (key),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .slot_i           (slot),
    .probe_count_i    (probe_count),
    .occupied_count_i (occupied_count),
    .error_count_o    (error_count),
    .pending_o        (pending),
    .used_slots_o     (used_slots)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: results are held off for a random hold, or a long hold when long_hold is set.
  initial begin
    int unsigned hold;
    forever begin
      if (long_hold) begin
        hold      = LongHoldCycles;
        long_hold = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(0, 13);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold - 1) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Keys often share a home slot so that probe chains get long.
  function automatic logic [KeyWidth-1:0] pick_key();
    longint unsigned raw, k;
    int unsigned     home, roll;
    raw  = $urandom & 32'h7FFF_FFFF;
    roll = $urandom_range(0, 99);
    if (roll < 3) return KeyMax[KeyWidth-1:0];
    if (roll < 40) home = HotBase + $urandom_range(0, HotSpan - 1);
    else home = $urandom_range(0, Slots - 1);
    k = raw - raw % Slots + home;
    if (k > KeyMax) k = k - Slots;
    return k[KeyWidth-1:0];
  endfunction

  task automatic send_item(input logic op, input logic [KeyWidth-1:0] k);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    do @(posedge clk); while (in_stall);
    if (op == OP_INSERT) begin
      inserts++;
      key_pool.push_back(k);
    end else begin
      searches++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [KeyWidth-1:0] k;
    int unsigned         needed;
    longint unsigned     fill_key;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // the core is still clearing its store here; config writes are taken
    write_mode(MODE_UNUSED);
    write_mode(MODE_DOUBLE);

    // directed: empty table, shared home slot, key extremes, duplicates
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_INSERT, 31'd0);
    send_item(OP_INSERT, 31'd1021);
    send_item(OP_INSERT, 31'd2042);
    send_item(OP_SEARCH, 31'd2042);
    send_item(OP_SEARCH, 31'd3063);
    send_item(OP_INSERT, 31'h7FFF_FFFF);
    send_item(OP_SEARCH, 31'h7FFF_FFFF);
    send_item(OP_INSERT, 31'h7FFF_FFFE);
    send_item(OP_SEARCH, 31'h7FFF_FFFE);
    send_item(OP_INSERT, 31'd0);
    send_item(OP_SEARCH, 31'd0);
    send_item(OP_INSERT, 31'd1020);
    send_item(OP_SEARCH, 31'd1020);
    send_item(OP_INSERT, 31'h5555_5555);
    send_item(OP_INSERT, 31'h2AAA_AAAA);
    send_item(OP_SEARCH, 31'h5555_5555);
    send_item(OP_SEARCH, 31'h2AAA_AAAA);
    send_item(OP_SEARCH, 31'd5);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       write_mode(MODE_LINEAR);
        1:       write_mode(MODE_QUAD);
        2:       write_mode(MODE_UNUSED);
        default: write_mode(MODE_DOUBLE);
      endcase
      long_hold = (p == 1);
      no_idle   = (p == 2);
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 40) begin
          if ($urandom_range(0, 9) == 0) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else k = pick_key();
          send_item(OP_INSERT, k);
        end else begin
          if ($urandom_range(0, 99) < 60) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else k = pick_key();
          send_item(OP_SEARCH, k);
        end
      end
      no_idle = 1'b0;
      drain();
    end

    // fill every remaining slot; double hashing reaches all slots of a prime table
    write_mode(MODE_DOUBLE);
    needed = Slots - used_slots;
    for (int unsigned j = 0; j < needed; j++) begin
      fill_key = j % Slots + longint'(Slots) * $urandom_range(0, 2_000_000);
      send_item(OP_INSERT, fill_key[KeyWidth-1:0]);
    end
    drain();

    // full table: overflow on insert, and search hits and misses; a miss runs the full count of probes
    write_mode(MODE_LINEAR);
    send_item(OP_INSERT, pick_key());
    send_item(OP_SEARCH, key_pool[0]);
    drain();
    write_mode(MODE_QUAD);
    send_item(OP_SEARCH, pick_key());
    send_item(OP_INSERT, 31'h7FFF_FFFF);
    drain();
    write_mode(MODE_UNUSED);
    send_item(OP_SEARCH, pick_key());
    send_item(OP_INSERT, 31'd0);
    drain();
    write_mode(MODE_DOUBLE);
    send_item(OP_SEARCH, 31'h1234_5678);
    send_item(OP_SEARCH, key_pool[key_pool.size() - 1]);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (TrailCycles) @(posedge clk);

    $display("Ran %0d inserts and %0d searches in all four probe mode settings,",
             inserts, searches);
    $display("with shared home slots, back-pressure on both sides and a table filled past full.");
    if (error_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ohash_pkg.sv
hdl/ohash_ram.sv
hdl/open_addressing_hash_table_core.sv
bench/open_addressing_hash_table_checker.sv
bench/open_addressing_hash_table_core_tb.sv
